// File: src/vbc_pkg.sv
package vbc_pkg;

	localparam int KEY_MAX = 64;
	localparam int KEY_AW  = $clog2(KEY_MAX);
	localparam int LEN_W   = $clog2(KEY_MAX + 1);

	localparam logic [7:0] CHAR_SPACE   = 8'h20;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CASE_GAP     = 8'd32;
	localparam logic [5:0] ALPHA_LEN    = 6'd26;

	localparam logic FUNC_KEY_WRITE = 1'b0;
	localparam logic FUNC_CIPHER    = 1'b1;

	localparam logic CFG_DECRYPT_MODE = 1'b0;
	localparam logic CFG_KEY_LENGTH   = 1'b1;

endpackage

// File: src/vbc_ram.sv
module vbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/vbc_shift.sv
module vbc_shift
	import vbc_pkg::*;
(
	input  logic [7:0] text_in,
	input  logic [7:0] key_in,
	input  logic       back,
	output logic [7:0] text_out
);

	logic       k_up;
	logic       k_lo;
	logic       t_up;
	logic       t_lo;
	logic [7:0] k_lc;
	logic [7:0] base;
	logic [4:0] amount;
	logic [4:0] v;
	logic [5:0] sum;
	logic [5:0] wrapped;

	always_comb begin
		k_up    = (key_in >= CHAR_UPPER_A) && (key_in <= CHAR_UPPER_Z);
		k_lo    = (key_in >= CHAR_LOWER_A) && (key_in <= CHAR_LOWER_Z);
		t_up    = (text_in >= CHAR_UPPER_A) && (text_in <= CHAR_UPPER_Z);
		t_lo    = (text_in >= CHAR_LOWER_A) && (text_in <= CHAR_LOWER_Z);
		k_lc    = k_up ? 8'(key_in + CASE_GAP) : key_in;
		base    = t_lo ? CHAR_LOWER_A : CHAR_UPPER_A;
		amount  = 5'(k_lc - CHAR_LOWER_A);
		v       = 5'(text_in - base);
		sum     = back ? 6'({1'b0, v} + ALPHA_LEN - {1'b0, amount})
		               : 6'({1'b0, v} + {1'b0, amount});
		wrapped = (sum >= ALPHA_LEN) ? 6'(sum - ALPHA_LEN) : sum;
		if ((k_up || k_lo) && (t_up || t_lo)) begin
			text_out = 8'(base + {2'b00, wrapped});
		end else begin
			text_out = text_in;
		end
	end

endmodule

// File: src/vigenere_byte_cipher_unit.sv
// Key write: accepted one item per cycle while idle, no result.
// Text item: a stale key position is first reduced by key_length until below it; the key
// store is then read from there, skipping key spaces, and the result is registered once a
// non-space key byte is read or the key holds only spaces; with key_length zero the result is
// registered at acceptance. Input is taken only while idle and stalls while a result waits.
// Reset clears key position, mode, key length (to 1) and output valid; key store is not cleared.
module vigenere_byte_cipher_unit
	import vbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // key_slot[5:0], line_start[6], data_byte[14:7], zero
	input  logic             s_tuser,   // func
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // text_out[7:0]
	output logic             m_tuser,   // key_error
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_NORM,
		ST_CHK,
		ST_HOLD
	} state_t;

	state_t            state_q;
	logic [KEY_AW-1:0] kpos_q;
	logic [KEY_AW-1:0] wpos_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              decrypt_q;
	logic [LEN_W-1:0]  key_length_q;
	logic [7:0]        byte_q;
	logic              m_valid_q;
	logic [7:0]        m_text_q;
	logic              m_err_q;
	logic [7:0]        hold_text_q;
	logic              hold_err_q;

	logic              in_accept;
	logic              in_func;
	logic [KEY_AW-1:0] in_slot;
	logic              in_line;
	logic [7:0]        in_byte;
	logic [LEN_W-1:0]  len;
	logic [KEY_AW-1:0] p0;
	logic              out_free;
	logic [7:0]        key_byte;
	logic              is_space;
	logic              last;
	logic [KEY_AW-1:0] nxt;
	logic              rd_en;
	logic [KEY_AW-1:0] rd_addr;
	logic              fin;
	logic [7:0]        fin_text;
	logic              fin_err;
	logic [7:0]        shifted;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign in_func   = s_tuser;
	assign in_slot   = s_tdata[5:0];
	assign in_line   = s_tdata[6];
	assign in_byte   = s_tdata[14:7];
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_text_q;
	assign m_tuser   = m_err_q;
	assign out_free  = !m_valid_q || m_tready;

	assign len      = (key_length_q > LEN_W'(KEY_MAX)) ? LEN_W'(KEY_MAX) : key_length_q;
	assign p0       = in_line ? '0 : kpos_q;
	assign is_space = (key_byte == CHAR_SPACE);
	assign last     = (LEN_W'(cnt_q + 1'b1) == len);
	assign nxt      = (LEN_W'({1'b0, wpos_q} + 1'b1) == len) ? '0 : KEY_AW'(wpos_q + 1'b1);

	vbc_ram #(
		.WIDTH(8),
		.DEPTH(KEY_MAX)
	) u_key_store (
		.clk   (clk),
		.we    (in_accept && (in_func == FUNC_KEY_WRITE)),
		.waddr (in_slot),
		.wdata (in_byte),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (key_byte)
	);

	vbc_shift u_shift (
		.text_in  (byte_q),
		.key_in   (key_byte),
		.back     (decrypt_q),
		.text_out (shifted)
	);

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = wpos_q;
		fin      = 1'b0;
		fin_text = byte_q;
		fin_err  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rd_addr = p0;
				if (in_accept && (in_func == FUNC_CIPHER)) begin
					if (len == '0) begin
						fin      = 1'b1;
						fin_text = in_byte;
						fin_err  = 1'b1;
					end else if ({1'b0, p0} < len) begin
						rd_en = 1'b1;
					end
				end
			end
			ST_NORM: begin
				rd_en = ({1'b0, wpos_q} < len);
			end
			ST_CHK: begin
				rd_addr = nxt;
				if (!is_space) begin
					fin      = 1'b1;
					fin_text = (byte_q == CHAR_SPACE) ? byte_q : shifted;
				end else if (last) begin
					fin     = 1'b1;
					fin_err = 1'b1;
				end else begin
					rd_en = 1'b1;
				end
			end
			ST_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kpos_q       <= '0;
			wpos_q       <= '0;
			cnt_q        <= '0;
			decrypt_q    <= 1'b0;
			key_length_q <= LEN_W'(1);
			byte_q       <= '0;
			m_valid_q    <= 1'b0;
			m_text_q     <= '0;
			m_err_q      <= 1'b0;
			hold_text_q  <= '0;
			hold_err_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DECRYPT_MODE: decrypt_q    <= cfg_wdata[0];
					CFG_KEY_LENGTH:   key_length_q <= cfg_wdata;
					default: begin
					end
				endcase
			end

			if (m_valid_q && m_tready && !fin && (state_q != ST_HOLD)) begin
				m_valid_q <= 1'b0;
			end

			if (fin) begin
				if (out_free) begin
					m_valid_q <= 1'b1;
					m_text_q  <= fin_text;
					m_err_q   <= fin_err;
					state_q   <= ST_IDLE;
				end else begin
					hold_text_q <= fin_text;
					hold_err_q  <= fin_err;
					state_q     <= ST_HOLD;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_func == FUNC_CIPHER)) begin
						kpos_q <= p0;
						wpos_q <= p0;
						byte_q <= in_byte;
						cnt_q  <= '0;
						if (len != '0) begin
							state_q <= ({1'b0, p0} < len) ? ST_CHK : ST_NORM;
						end
					end
				end
				ST_NORM: begin
					if ({1'b0, wpos_q} < len) begin
						cnt_q   <= '0;
						state_q <= ST_CHK;
					end else begin
						wpos_q <= KEY_AW'({1'b0, wpos_q} - len);
					end
				end
				ST_CHK: begin
					if (!is_space) begin
						kpos_q <= (byte_q == CHAR_SPACE) ? wpos_q : nxt;
					end else if (!last) begin
						wpos_q <= nxt;
						cnt_q  <= LEN_W'(cnt_q + 1'b1);
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						m_text_q  <= hold_text_q;
						m_err_q   <= hold_err_q;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: dv/vigenere_cipher_check.sv
module vigenere_cipher_check
	import vbc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [15:0]      s_tdata,   // key_slot[5:0], line_start[6], data_byte[14:7], zero
	input  logic             s_tuser,   // func
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [7:0]       m_tdata,   // text_out[7:0]
	input  logic             m_tuser,   // key_error
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_wdata,
	output int               fail_count,
	output int               pending
);

	typedef struct packed {
		logic [7:0] text;
		logic       err;
	} cipher_res_t;

	logic [7:0]        key_mem [KEY_MAX];
	logic [KEY_AW-1:0] key_pos;
	logic              decrypt;
	logic [LEN_W-1:0]  key_len;
	cipher_res_t       cipher_q[$];
	cipher_res_t       want;
	int                fails = 0;
	int                waiting = 0;

	assign fail_count = fails;
	assign pending    = waiting;

	function automatic logic [7:0] shift_byte(input logic [7:0] t, input logic [7:0] k,
			input logic back);
		logic [7:0] kl;
		logic [7:0] base;
		int         amt;
		int         v;
		kl = k;
		if (k >= CHAR_UPPER_A && k <= CHAR_UPPER_Z) begin
			kl = k + CASE_GAP;
		end else if (!(k >= CHAR_LOWER_A && k <= CHAR_LOWER_Z)) begin
			return t;
		end
		if (t >= CHAR_LOWER_A && t <= CHAR_LOWER_Z) begin
			base = CHAR_LOWER_A;
		end else if (t >= CHAR_UPPER_A && t <= CHAR_UPPER_Z) begin
			base = CHAR_UPPER_A;
		end else begin
			return t;
		end
		amt = int'(kl) - int'(CHAR_LOWER_A);
		v   = int'(t) - int'(base);
		if (back) begin
			v = (v + int'(ALPHA_LEN) - amt) % int'(ALPHA_LEN);
		end else begin
			v = (v + amt) % int'(ALPHA_LEN);
		end
		return base + v[7:0];
	endfunction

	task automatic predict_text(input logic line, input logic [7:0] b);
		int          len;
		int          p;
		int          n;
		logic        found;
		cipher_res_t r;
		if (line) begin
			key_pos = '0;
		end
		len   = (key_len > KEY_MAX) ? KEY_MAX : int'(key_len);
		found = 1'b0;
		p     = 0;
		if (len != 0) begin
			p = key_pos % len;
			// skip key spaces, wrapping at the key length
			for (n = 0; n < len && !found; n++) begin
				if (key_mem[p] != CHAR_SPACE) begin
					found = 1'b1;
				end else begin
					p = (p + 1) % len;
				end
			end
		end
		if (!found) begin
			r = '{text: b, err: 1'b1};
		end else if (b == CHAR_SPACE) begin
			key_pos = p[KEY_AW-1:0];
			r = '{text: b, err: 1'b0};
		end else begin
			r = '{text: shift_byte(b, key_mem[p], decrypt), err: 1'b0};
			key_pos = KEY_AW'((p + 1) % len);
		end
		cipher_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_pos = '0;
			decrypt = 1'b0;
			key_len = LEN_W'(1);
			cipher_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (cipher_q.size() == 0) begin
					fails++;
					$display("%0t: unexpected item text_out %h key_error %b", $time,
						m_tdata, m_tuser);
				end else begin
					want = cipher_q.pop_front();
					if (m_tdata !== want.text) begin
						fails++;
						$display("%0t: text_out expected %h actual %h", $time,
							want.text, m_tdata);
					end
					if (m_tuser !== want.err) begin
						fails++;
						$display("%0t: key_error expected %b actual %b", $time,
							want.err, m_tuser);
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_DECRYPT_MODE) begin
					decrypt = cfg_wdata[0];
				end else begin
					key_len = cfg_wdata;
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == FUNC_KEY_WRITE) begin
					key_mem[s_tdata[5:0]] = s_tdata[14:7];
				end else begin
					predict_text(s_tdata[6], s_tdata[14:7]);
				end
			end
		end
		waiting = cipher_q.size();
	end

endmodule

// File: dv/tb_vigenere_byte_cipher_unit.sv
module tb_vigenere_byte_cipher_unit;
	import vbc_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 200;

	typedef enum int {KEY_MIXED, KEY_LETTERS, KEY_SPACES} key_mix_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [15:0]      s_tdata;   // key_slot[5:0], line_start[6], data_byte[14:7], zero
	logic             s_tuser;   // func
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;   // text_out[7:0]
	logic             m_tuser;   // key_error
	logic             cfg_we;
	logic             cfg_index;
	logic [LEN_W-1:0] cfg_wdata;
	int               fail_count;
	int               pending;

	int idle_pct  = 0;
	int stall_pct = 0;
	bit hold_req  = 0;
	int text_sent = 0;
	int key_sent  = 0;
	int settings  = 0;

	vigenere_byte_cipher_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	vigenere_cipher_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("FAIL vigenere_byte_cipher_unit");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic logic [7:0] letter_byte();
		logic [7:0] base;
		base = $urandom_range(1) ? CHAR_UPPER_A : CHAR_LOWER_A;
		return base + 8'($urandom_range(25));
	endfunction

	function automatic logic [7:0] key_byte(input key_mix_t mix);
		int r;
		r = $urandom_range(99);
		if (mix == KEY_SPACES) begin
			return CHAR_SPACE;
		end else if (mix == KEY_LETTERS) begin
			return (r < 90) ? letter_byte() : CHAR_SPACE;
		end
		if (r < 45) begin
			return letter_byte();
		end else if (r < 70) begin
			return CHAR_SPACE;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 55) begin
			return letter_byte();
		end else if (r < 70) begin
			return CHAR_SPACE;
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic send(input logic func, input logic [5:0] slot, input logic line,
			input logic [7:0] b);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= func;
		s_tdata  <= {1'b0, b, line, slot};
		do @(posedge clk); while (!s_tready);
		if (func == FUNC_CIPHER) begin
			text_sent++;
		end else begin
			key_sent++;
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic dec, input int len);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DECRYPT_MODE;
		cfg_wdata <= LEN_W'(dec);
		@(posedge clk);
		cfg_index <= CFG_KEY_LENGTH;
		cfg_wdata <= LEN_W'(len);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_phase(input logic dec, input int len, input int idle, input int stall,
			input int n_text, input key_mix_t mix, input bit hold);
		int lim;
		set_config(dec, len);
		idle_pct  = idle;
		stall_pct = stall;
		lim = (len > KEY_MAX) ? KEY_MAX : len;
		for (int i = 0; i < lim; i++) begin
			send(FUNC_KEY_WRITE, 6'(i), 1'($urandom_range(1)), key_byte(mix));
		end
		if (hold) begin
			hold_req = 1;
		end
		for (int i = 0; i < n_text; i++) begin
			if ($urandom_range(99) < 6) begin
				send(FUNC_KEY_WRITE, 6'($urandom_range(63)), 1'($urandom_range(1)),
					key_byte(mix));
			end
			send(FUNC_CIPHER, 6'($urandom_range(63)), ($urandom_range(99) < 8),
				text_byte());
		end
		settle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= FUNC_KEY_WRITE;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_DECRYPT_MODE;
		cfg_wdata <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: shift extremes, key space skip, non-letter key and text
		set_config(1'b0, 4);
		send(FUNC_KEY_WRITE, 6'd0, 1'b0, "a");
		send(FUNC_KEY_WRITE, 6'd1, 1'b0, "Z");
		send(FUNC_KEY_WRITE, 6'd2, 1'b0, " ");
		send(FUNC_KEY_WRITE, 6'd3, 1'b0, "#");
		send(FUNC_CIPHER, 6'd0, 1'b1, "a");
		send(FUNC_CIPHER, 6'd63, 1'b0, "z");
		send(FUNC_CIPHER, 6'd0, 1'b0, " ");
		send(FUNC_CIPHER, 6'd0, 1'b0, "M");
		send(FUNC_CIPHER, 6'd0, 1'b0, 8'h00);
		send(FUNC_CIPHER, 6'd0, 1'b0, 8'hff);
		send(FUNC_CIPHER, 6'd0, 1'b0, "{");
		send(FUNC_CIPHER, 6'd0, 1'b0, "@");
		send(FUNC_CIPHER, 6'd0, 1'b1, "Z");
		settle();
		// decrypt with key length 2
		set_config(1'b1, 2);
		send(FUNC_CIPHER, 6'd0, 1'b0, "a");
		send(FUNC_CIPHER, 6'd0, 1'b0, "A");
		send(FUNC_KEY_WRITE, 6'd63, 1'b1, 8'hff);
		send(FUNC_KEY_WRITE, 6'd0, 1'b0, " ");
		settle();
		// key of only spaces
		set_config(1'b0, 1);
		send(FUNC_CIPHER, 6'd0, 1'b0, "q");
		settle();

		run_phase(1'b0, 5,   0,  0,  120, KEY_MIXED,   0);
		run_phase(1'b1, 64,  73, 0,  120, KEY_LETTERS, 0);
		run_phase(1'b0, 1,   0,  73, 120, KEY_LETTERS, 1);
		run_phase(1'b1, 127, 19, 19, 120, KEY_MIXED,   0);
		run_phase(1'b0, 0,   0,  0,  25,  KEY_MIXED,   0);
		run_phase(1'b1, 20,  73, 0,  25,  KEY_SPACES,  0);
		run_phase(1'b0, 9,   19, 19, 100, KEY_MIXED,   0);
		run_phase(1'b1, 33,  0,  0,  100, KEY_LETTERS, 0);
		run_phase(1'b0, 64,  0,  73, 80,  KEY_MIXED,   0);

		$display("%0d text items and %0d key writes over %0d mode and key length settings",
			text_sent, key_sent, settings);
		$display("lengths 0 to 127, all-space keys, idle and stall mixes, one long hold-off");
		if (fail_count == 0) begin
			$display("PASS vigenere_byte_cipher_unit");
		end else begin
			$display("FAIL vigenere_byte_cipher_unit");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/vbc_pkg.sv
src/vbc_ram.sv
src/vbc_shift.sv
src/vigenere_byte_cipher_unit.sv
dv/vigenere_cipher_check.sv
dv/tb_vigenere_byte_cipher_unit.sv
